@@ rtl/core/irc_pkg.sv @@
// irc_pkg: shared types, verdict codes and ones'-complement helper for the
// ipv4 receive checker; no dependencies
package irc_pkg;

	localparam logic [3:0] V_NOT_IPV4    = 4'd0;
	localparam logic [3:0] V_NOT_MINE    = 4'd1;
	localparam logic [3:0] V_TRUNCATED   = 4'd2;
	localparam logic [3:0] V_BAD_HDR_SUM = 4'd3;
	localparam logic [3:0] V_BAD_TCP_SUM = 4'd4;
	localparam logic [3:0] V_TCP_OK      = 4'd5;
	localparam logic [3:0] V_ECHO_REQ    = 4'd6;
	localparam logic [3:0] V_OTHER_ICMP  = 4'd7;
	localparam logic [3:0] V_OTHER_PROTO = 4'd8;

	localparam logic [7:0] PROTO_ICMP     = 8'h01;
	localparam logic [7:0] PROTO_TCP      = 8'h06;
	localparam logic [7:0] ICMP_ECHO_REQ  = 8'h08;
	localparam logic [3:0] IP_VERSION_4   = 4'h4;
	localparam logic [15:0] MIN_HDR_BYTES = 16'd20;

	// per-packet parse state
	typedef struct packed {
		logic [15:0] byte_position;
		logic [3:0]  header_words_len;
		logic [15:0] total_length;
		logic [15:0] header_sum;
		logic [15:0] segment_sum;
		logic [7:0]  protocol_number;
		logic        version_good;
		logic        dest_matches;
		logic [31:0] sender_address;
		logic [15:0] datagram_id;
		logic [7:0]  first_type_byte;
	} pkt_state_t;

	// end-around carry add
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

@@ rtl/core/irc_parse.sv @@
// irc_parse: per-packet header parser and checksum accumulators
// depends on irc_pkg
module irc_parse (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [15:0]             data_word,
	input  logic                    last_word,
	input  logic [31:0]             my_address,
	output irc_pkg::pkt_state_t     state_next
);
	import irc_pkg::*;

	localparam logic [14:0] W_VER_IHL = 15'd0;
	localparam logic [14:0] W_TOT_LEN = 15'd1;
	localparam logic [14:0] W_IDENT   = 15'd2;
	localparam logic [14:0] W_PROTO   = 15'd4;
	localparam logic [14:0] W_SRC_HI  = 15'd6;
	localparam logic [14:0] W_SRC_LO  = 15'd7;
	localparam logic [14:0] W_DST_HI  = 15'd8;
	localparam logic [14:0] W_DST_LO  = 15'd9;

	pkt_state_t  st_q;
	pkt_state_t  nx;
	logic [15:0] pos;
	logic [14:0] idx;
	logic        take;
	logic        odd_end;
	logic [15:0] sw;
	logic [4:0]  hw;
	logic        in_hdr;
	logic [15:0] seg1;

	always_comb begin
		pos     = st_q.byte_position;
		idx     = pos[15:1];
		take    = (pos < 16'd4) || (pos < st_q.total_length);
		odd_end = (pos >= 16'd4) && (({1'b0, pos} + 17'd1) == {1'b0, st_q.total_length});
		sw      = odd_end ? {data_word[15:8], 8'h00} : data_word;
		nx      = st_q;
		hw      = 5'd0;
		in_hdr  = 1'b0;
		seg1    = st_q.segment_sum;
		if (take) begin
			case (idx)
				W_VER_IHL: begin
					nx.version_good     = (data_word[15:12] == IP_VERSION_4);
					nx.header_words_len = data_word[11:8];
				end
				W_TOT_LEN: nx.total_length = data_word;
				W_IDENT:   nx.datagram_id = data_word;
				W_PROTO:   nx.protocol_number = data_word[7:0];
				W_SRC_HI:  nx.sender_address[31:16] = data_word;
				W_SRC_LO:  nx.sender_address[15:0] = data_word;
				W_DST_HI:  nx.dest_matches = (data_word == my_address[31:16]);
				W_DST_LO:  nx.dest_matches = st_q.dest_matches && (data_word == my_address[15:0]);
				default: ;
			endcase
			hw     = {nx.header_words_len, 1'b0};
			in_hdr = idx < {10'd0, hw};
			if (in_hdr) begin
				nx.header_sum = oc_add(st_q.header_sum, sw);
			end else begin
				seg1 = oc_add(st_q.segment_sum, sw);
				if (idx == {10'd0, hw})
					nx.first_type_byte = sw[15:8];
			end
			// source and destination go into the tcp pseudo-header
			if (idx >= W_SRC_HI && idx <= W_DST_LO)
				nx.segment_sum = oc_add(seg1, data_word);
			else
				nx.segment_sum = seg1;
		end
		nx.byte_position = (pos >= 16'hFFFE) ? 16'hFFFF : pos + 16'd2;
		state_next = nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= last_word ? '0 : nx;
		end
	end

endmodule

@@ rtl/core/irc_verdict.sv @@
// irc_verdict: end-of-packet classification from the final parse state
// depends on irc_pkg
module irc_verdict (
	input  irc_pkg::pkt_state_t st,
	output logic [3:0]          verdict,
	output logic [15:0]         payload_length
);
	import irc_pkg::*;

	logic [15:0] hbytes;
	logic [15:0] plen;
	logic [15:0] ts;

	always_comb begin
		hbytes = {10'd0, st.header_words_len, 2'b00};
		plen   = (st.total_length >= hbytes) ? st.total_length - hbytes : 16'd0;
		ts     = oc_add(oc_add(st.segment_sum, {8'd0, PROTO_TCP}), plen);
		if (!st.version_good)
			verdict = V_NOT_IPV4;
		else if (st.byte_position < MIN_HDR_BYTES || st.total_length < MIN_HDR_BYTES)
			verdict = V_TRUNCATED;
		else if (!st.dest_matches)
			verdict = V_NOT_MINE;
		else if (st.header_words_len < 4'd5 || st.total_length < hbytes ||
				st.byte_position < st.total_length)
			verdict = V_TRUNCATED;
		else if (st.protocol_number == PROTO_ICMP)
			verdict = (st.first_type_byte == ICMP_ECHO_REQ) ? V_ECHO_REQ : V_OTHER_ICMP;
		else if (st.protocol_number == PROTO_TCP) begin
			if (st.header_sum != 16'hFFFF)
				verdict = V_BAD_HDR_SUM;
			else if (ts != 16'hFFFF)
				verdict = V_BAD_TCP_SUM;
			else
				verdict = V_TCP_OK;
		end else
			verdict = V_OTHER_PROTO;
		payload_length = plen;
	end

endmodule

@@ rtl/core/ipv4_receive_checker.sv @@
// ipv4_receive_checker: top level, input register, parser, final-state register
// and result register; depends on irc_pkg, irc_parse, irc_verdict
// throughput: one packet word per cycle, sustained, with out_ready held high
// result path: the last word of a packet goes from the input register through the parse stage
//   into the final-state register, then through the verdict stage into the output register
// reset: arst_n clears all valid flags, parse state and my_address to zero
module ipv4_receive_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] data_word,
	input  logic        last_word,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  verdict,
	output logic [15:0] payload_length,
	output logic [31:0] source_address,
	output logic [15:0] identification
);
	import irc_pkg::*;

	logic [31:0] my_addr_q;
	logic        vld_s1;
	logic [15:0] word_s1;
	logic        last_s1;
	logic        vld_s2;
	pkt_state_t  st_s2;
	pkt_state_t  st_next;
	logic        out_vld_q;
	logic [3:0]  verdict_q;
	logic [15:0] plen_q;
	logic [31:0] src_q;
	logic [15:0] ident_q;
	logic [3:0]  verdict_c;
	logic [15:0] plen_c;
	logic        out_free;
	logic        s2_free;
	logic        step;

	assign out_free = !out_vld_q || out_ready;
	assign s2_free  = !vld_s2 || out_free;
	// a last word may only leave the input register when the final-state slot frees
	assign step     = vld_s1 && (!last_s1 || s2_free);
	assign in_ready = !vld_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_addr_q <= '0;
		end else if (cfg_wr_en) begin
			my_addr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (s2_free)
				vld_s2 <= step && last_s1;
			if (out_free)
				out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= data_word;
			last_s1 <= last_word;
		end
		if (step && last_s1 && s2_free)
			st_s2 <= st_next;
		if (vld_s2 && out_free) begin
			verdict_q <= verdict_c;
			plen_q    <= plen_c;
			src_q     <= st_s2.sender_address;
			ident_q   <= st_s2.datagram_id;
		end
	end

	irc_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_word  (word_s1),
		.last_word  (last_s1),
		.my_address (my_addr_q),
		.state_next (st_next)
	);

	irc_verdict u_verdict (
		.st             (st_s2),
		.verdict        (verdict_c),
		.payload_length (plen_c)
	);

	assign out_valid      = out_vld_q;
	assign verdict        = verdict_q;
	assign payload_length = plen_q;
	assign source_address = src_q;
	assign identification = ident_q;

endmodule

@@ rtl/core/irc_checker.sv @@
// irc_checker: port-level assertions for ipv4_receive_checker, bound to the top
// depends on irc_pkg
module irc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  verdict,
	input logic [15:0] payload_length,
	input logic [31:0] source_address,
	input logic [15:0] identification
);
	import irc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict) &&
		$stable(payload_length) && $stable(source_address) && $stable(identification))
		else $error("result changed while stalled");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict <= V_OTHER_PROTO)
		else $error("verdict code out of range");

	// a free output slot must let the pipeline take a new request
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with output free");

	// tcp ok implies the header carried at least the minimum length
	a_tcp_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == V_TCP_OK |-> payload_length <= 16'd65515)
		else $error("tcp ok with impossible payload length");

endmodule

bind ipv4_receive_checker irc_checker u_irc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.verdict        (verdict),
	.payload_length (payload_length),
	.source_address (source_address),
	.identification (identification)
);
